/* hw/rtl/mhd_pkg.sv */
// shared types and constants for the mahalanobis distance block
`timescale 1ns / 1ps

package mhd_pkg;

  localparam int CovW     = 32;
  localparam int CofW     = 65;
  localparam int DetW     = 97;
  localparam int DiffW    = 22;
  localparam int AngW     = 17;
  localparam int MW       = 44;
  localparam int PpW      = 56;
  localparam int QfW      = 110;
  localparam int RemW     = 96;
  localparam int DivSteps = 32;
  localparam int NTerms   = 6;

  localparam logic [15:0] PiQ13    = 16'd25736;
  localparam logic [15:0] TwoPiQ13 = 16'd51472;

  localparam logic [2:0] SettleCycles = 3'd4;

  typedef enum logic [3:0] {
    RegMeanXy    = 4'd0,
    RegMeanAngle = 4'd1,
    RegCovXx     = 4'd2,
    RegCovXy     = 4'd3,
    RegCovXa     = 4'd4,
    RegCovYy     = 4'd5,
    RegCovYa     = 4'd6,
    RegCovAa     = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [CovW-1:0] xx;
    logic signed [CovW-1:0] xy;
    logic signed [CovW-1:0] xa;
    logic signed [CovW-1:0] yy;
    logic signed [CovW-1:0] ya;
    logic signed [CovW-1:0] aa;
  } cov_t;

  typedef struct packed {
    logic signed [CofW-1:0] a00;
    logic signed [CofW-1:0] a01;
    logic signed [CofW-1:0] a02;
    logic signed [CofW-1:0] a11;
    logic signed [CofW-1:0] a12;
    logic signed [CofW-1:0] a22;
  } cof_t;

  typedef struct packed {
    logic inf;
    logic neg;
    logic sat;
  } flags_t;

endpackage

/* hw/rtl/mhd_cov_calc.sv */
// adjugate and determinant of the configured covariance, free-running pipeline
`timescale 1ns / 1ps

module mhd_cov_calc (
  input  logic                          clk_i,
  input  mhd_pkg::cov_t                 cov_i,
  output mhd_pkg::cof_t                 cof_o,
  output logic signed [mhd_pkg::DetW-1:0] det_o
);

  logic signed [2*mhd_pkg::CovW-1:0] df_q, ee_q, ce_q, bf_q, be_q, cd_q;
  logic signed [2*mhd_pkg::CovW-1:0] af_q, cc_q, bc_q, ae_q, ad_q, bb_q;
  mhd_pkg::cof_t cof_q;
  logic signed [mhd_pkg::CofW-1:0] lo_d [3];
  logic signed [mhd_pkg::CofW-1:0] hi_d [3];
  logic signed [mhd_pkg::CofW-1:0] lo_q [3];
  logic signed [mhd_pkg::CofW-1:0] hi_q [3];
  logic signed [mhd_pkg::DetW-1:0] det_q;

  // products of entry pairs
  always_ff @(posedge clk_i) begin
    df_q <= $signed(cov_i.yy) * $signed(cov_i.aa);
    ee_q <= $signed(cov_i.ya) * $signed(cov_i.ya);
    ce_q <= $signed(cov_i.xa) * $signed(cov_i.ya);
    bf_q <= $signed(cov_i.xy) * $signed(cov_i.aa);
    be_q <= $signed(cov_i.xy) * $signed(cov_i.ya);
    cd_q <= $signed(cov_i.xa) * $signed(cov_i.yy);
    af_q <= $signed(cov_i.xx) * $signed(cov_i.aa);
    cc_q <= $signed(cov_i.xa) * $signed(cov_i.xa);
    bc_q <= $signed(cov_i.xy) * $signed(cov_i.xa);
    ae_q <= $signed(cov_i.xx) * $signed(cov_i.ya);
    ad_q <= $signed(cov_i.xx) * $signed(cov_i.yy);
    bb_q <= $signed(cov_i.xy) * $signed(cov_i.xy);
  end

  // cofactors
  always_ff @(posedge clk_i) begin
    cof_q.a00 <= mhd_pkg::CofW'(df_q) - mhd_pkg::CofW'(ee_q);
    cof_q.a01 <= mhd_pkg::CofW'(ce_q) - mhd_pkg::CofW'(bf_q);
    cof_q.a02 <= mhd_pkg::CofW'(be_q) - mhd_pkg::CofW'(cd_q);
    cof_q.a11 <= mhd_pkg::CofW'(af_q) - mhd_pkg::CofW'(cc_q);
    cof_q.a12 <= mhd_pkg::CofW'(bc_q) - mhd_pkg::CofW'(ae_q);
    cof_q.a22 <= mhd_pkg::CofW'(ad_q) - mhd_pkg::CofW'(bb_q);
  end

  // determinant partial products, cofactor split in two halves
  always_comb begin
    lo_d[0] = $signed({1'b0, cof_q.a00[31:0]}) * $signed(cov_i.xx);
    hi_d[0] = $signed(cof_q.a00[64:32]) * $signed(cov_i.xx);
    lo_d[1] = $signed({1'b0, cof_q.a01[31:0]}) * $signed(cov_i.xy);
    hi_d[1] = $signed(cof_q.a01[64:32]) * $signed(cov_i.xy);
    lo_d[2] = $signed({1'b0, cof_q.a02[31:0]}) * $signed(cov_i.xa);
    hi_d[2] = $signed(cof_q.a02[64:32]) * $signed(cov_i.xa);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      lo_q[k] <= lo_d[k];
      hi_q[k] <= hi_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    det_q <= (mhd_pkg::DetW'(hi_q[0]) <<< 32) + mhd_pkg::DetW'(lo_q[0])
           + (mhd_pkg::DetW'(hi_q[1]) <<< 32) + mhd_pkg::DetW'(lo_q[1])
           + (mhd_pkg::DetW'(hi_q[2]) <<< 32) + mhd_pkg::DetW'(lo_q[2]);
  end

  assign cof_o = cof_q;
  assign det_o = det_q;

endmodule

/* hw/rtl/mhd_quad.sv */
// difference vector and quadratic form with the adjugate, six stages
`timescale 1ns / 1ps

module mhd_quad (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [15:0]             pos_x_i,
  input  logic signed [15:0]             pos_y_i,
  input  logic [15:0]                    pos_angle_i,
  input  logic [31:0]                    mean_xy_i,
  input  logic [15:0]                    mean_angle_i,
  input  mhd_pkg::cof_t                  cof_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic signed [mhd_pkg::QfW-1:0] qf_o
);

  localparam int DW = mhd_pkg::DiffW;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  logic signed [DW-1:0]              dx_q, dy_q;
  logic signed [mhd_pkg::AngW-1:0]   da_q;
  logic signed [DW-1:0]              dx_d, dy_d;
  logic signed [mhd_pkg::AngW-1:0]   da_d;

  logic signed [mhd_pkg::MW-1:0]     m_d [mhd_pkg::NTerms];
  logic signed [mhd_pkg::MW-1:0]     m_q [mhd_pkg::NTerms];
  logic signed [mhd_pkg::PpW-1:0]    pp_d [mhd_pkg::NTerms][4];
  logic signed [mhd_pkg::PpW-1:0]    pp_q [mhd_pkg::NTerms][4];
  logic signed [mhd_pkg::QfW-1:0]    term_d [mhd_pkg::NTerms];
  logic signed [mhd_pkg::QfW-1:0]    term_q [mhd_pkg::NTerms];
  logic signed [mhd_pkg::QfW-1:0]    pair_q [3];
  logic signed [mhd_pkg::QfW-1:0]    qf_q;

  assign en6 = !v6_q || ready_i;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // stage 1: differences, angle wrap
  always_comb begin
    logic signed [16:0] ddx, ddy, dar, pis, two_pis;
    logic               wrap;
    ddx     = $signed({pos_x_i[15], pos_x_i}) - $signed({mean_xy_i[15], mean_xy_i[15:0]});
    ddy     = $signed({pos_y_i[15], pos_y_i}) - $signed({mean_xy_i[31], mean_xy_i[31:16]});
    dar     = $signed({1'b0, pos_angle_i}) - $signed({1'b0, mean_angle_i});
    pis     = $signed({1'b0, mhd_pkg::PiQ13});
    two_pis = $signed({1'b0, mhd_pkg::TwoPiQ13});
    wrap    = (pos_angle_i <= mhd_pkg::TwoPiQ13) && (mean_angle_i <= mhd_pkg::TwoPiQ13)
              && ((dar > pis) || (dar < -pis));
    dx_d    = {ddx, 5'b0};
    dy_d    = {ddy, 5'b0};
    if (wrap) begin
      da_d = dar[16] ? dar + two_pis : dar - two_pis;
    end else begin
      da_d = dar;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      da_q <= da_d;
    end
  end

  // stage 2: monomials of the difference
  always_comb begin
    logic signed [DW-1:0]             dae;
    logic signed [mhd_pkg::MW-1:0]    pxy, pxa, pya;
    dae     = {{(DW - mhd_pkg::AngW){da_q[mhd_pkg::AngW-1]}}, da_q};
    m_d[0]  = dx_q * dx_q;
    m_d[1]  = dy_q * dy_q;
    m_d[2]  = dae * dae;
    pxy     = dx_q * dy_q;
    pxa     = dx_q * dae;
    pya     = dy_q * dae;
    m_d[3]  = pxy <<< 1;
    m_d[4]  = pxa <<< 1;
    m_d[5]  = pya <<< 1;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int k = 0; k < mhd_pkg::NTerms; k++) m_q[k] <= m_d[k];
    end
  end

  // stage 3: partial products of cofactor times monomial
  always_comb begin
    logic signed [mhd_pkg::CofW-1:0] cof [mhd_pkg::NTerms];
    cof[0] = cof_i.a00;
    cof[1] = cof_i.a11;
    cof[2] = cof_i.a22;
    cof[3] = cof_i.a01;
    cof[4] = cof_i.a02;
    cof[5] = cof_i.a12;
    for (int k = 0; k < mhd_pkg::NTerms; k++) begin
      pp_d[k][0] = $signed({1'b0, cof[k][31:0]}) * $signed({1'b0, m_q[k][21:0]});
      pp_d[k][1] = $signed({1'b0, cof[k][31:0]}) * $signed(m_q[k][43:22]);
      pp_d[k][2] = $signed(cof[k][64:32]) * $signed({1'b0, m_q[k][21:0]});
      pp_d[k][3] = $signed(cof[k][64:32]) * $signed(m_q[k][43:22]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int k = 0; k < mhd_pkg::NTerms; k++) begin
        for (int j = 0; j < 4; j++) pp_q[k][j] <= pp_d[k][j];
      end
    end
  end

  // stage 4: recombine partial products
  always_comb begin
    for (int k = 0; k < mhd_pkg::NTerms; k++) begin
      term_d[k] = mhd_pkg::QfW'(pp_q[k][0])
                + (mhd_pkg::QfW'(pp_q[k][1]) <<< 22)
                + (mhd_pkg::QfW'(pp_q[k][2]) <<< 32)
                + (mhd_pkg::QfW'(pp_q[k][3]) <<< 54);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      for (int k = 0; k < mhd_pkg::NTerms; k++) term_q[k] <= term_d[k];
    end
  end

  // stages 5 and 6: sum of terms
  always_ff @(posedge clk_i) begin
    if (en5) begin
      pair_q[0] <= term_q[0] + term_q[1];
      pair_q[1] <= term_q[2] + term_q[3];
      pair_q[2] <= term_q[4] + term_q[5];
    end
    if (en6) begin
      qf_q <= pair_q[0] + pair_q[1] + pair_q[2];
    end
  end

  assign valid_o = v6_q;
  assign qf_o    = qf_q;

endmodule

/* hw/rtl/mhd_div.sv */
// range checks and pipelined restoring division by the determinant
`timescale 1ns / 1ps

module mhd_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic signed [mhd_pkg::QfW-1:0]  qf_i,
  input  logic signed [mhd_pkg::DetW-1:0] det_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [31:0]                     distance_sq_o,
  output logic                            is_infinite_o,
  output logic                            saturated_o
);

  localparam int NS = mhd_pkg::DivSteps;

  logic [NS:0]                 v_q;
  logic [NS:0]                 en;
  logic [mhd_pkg::RemW-1:0]    rem_q [NS+1];
  logic [31:0]                 lo_q  [NS+1];
  logic [31:0]                 quo_q [NS+1];
  mhd_pkg::flags_t             flg_q [NS+1];

  logic [mhd_pkg::RemW:0]      dext;
  mhd_pkg::flags_t             flg_d;
  logic [82:0]                 hi;

  assign dext = {1'b0, det_i[mhd_pkg::RemW-1:0]};

  assign en[NS] = !v_q[NS] || ready_i;
  assign ready_o = en[0];

  // step 0: sign, determinant and overflow checks
  always_comb begin
    hi        = qf_i[108:26];
    flg_d.inf = det_i[mhd_pkg::DetW-1] || (det_i == '0);
    flg_d.neg = qf_i[mhd_pkg::QfW-1];
    flg_d.sat = {14'b0, hi} >= dext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en[0]) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rem_q[0] <= mhd_pkg::RemW'(hi);
      lo_q[0]  <= {qf_i[25:0], 6'b0};
      quo_q[0] <= '0;
      flg_q[0] <= flg_d;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [mhd_pkg::RemW:0] t;
    logic                   ge;

    if (k < NS) begin : g_en
      assign en[k] = !v_q[k] || en[k+1];
    end

    if (k == 1) begin : g_en0
      assign en[0] = !v_q[0] || en[1];
    end

    assign t  = {rem_q[k-1], lo_q[k-1][31]};
    assign ge = t >= dext;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k] <= ge ? mhd_pkg::RemW'(t - dext) : t[mhd_pkg::RemW-1:0];
        lo_q[k]  <= {lo_q[k-1][30:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][30:0], ge};
        flg_q[k] <= flg_q[k-1];
      end
    end
  end

  always_comb begin
    if (flg_q[NS].inf) begin
      distance_sq_o = '1;
    end else if (flg_q[NS].neg) begin
      distance_sq_o = '0;
    end else if (flg_q[NS].sat) begin
      distance_sq_o = '1;
    end else begin
      distance_sq_o = quo_q[NS];
    end
  end

  assign is_infinite_o = flg_q[NS].inf;
  assign saturated_o   = !flg_q[NS].inf && (flg_q[NS].neg || flg_q[NS].sat);
  assign valid_o       = v_q[NS];

endmodule

/* hw/rtl/mahalanobis_dist_x_y_angle.sv */
// top level: registers, covariance precompute, distance pipeline
`timescale 1ns / 1ps

// channel | direction | payload
// in      | sink      | pos_x_i, pos_y_i, pos_angle_i
// out     | source    | distance_sq_o, is_infinite_o, saturated_o
// cfg     | sink      | cfg_index_i, cfg_data_i
//
// one beat per cycle unless back pressure or settling stalls the pipeline
// the pipeline holds 6 quadratic form stages, one range check stage and 32 division steps,
// one quotient bit each
// after reset and after every register write in_ready_o stays low
// while the adjugate and determinant settle
// every stage holds under back pressure and empty stages fill, so nothing is lost

module mahalanobis_dist_x_y_angle (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [15:0]        pos_angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        distance_sq_o,
  output logic               is_infinite_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic [31:0]                     mean_xy_q;
  logic [15:0]                     mean_angle_q;
  mhd_pkg::cov_t                   cov_q;
  logic [2:0]                      settle_q;
  mhd_pkg::cof_t                   cof;
  logic signed [mhd_pkg::DetW-1:0] det;
  logic                            quad_ready, quad_valid, settled;
  logic signed [mhd_pkg::QfW-1:0]  qf;
  logic                            div_ready;

  assign cfg_ready_o = 1'b1;
  assign settled     = (settle_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_xy_q    <= '0;
      mean_angle_q <= '0;
      cov_q.xx     <= 32'sd65536;
      cov_q.xy     <= '0;
      cov_q.xa     <= '0;
      cov_q.yy     <= 32'sd65536;
      cov_q.ya     <= '0;
      cov_q.aa     <= 32'sd65536;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mhd_pkg::RegMeanXy:    mean_xy_q    <= cfg_data_i;
        mhd_pkg::RegMeanAngle: mean_angle_q <= cfg_data_i[15:0];
        mhd_pkg::RegCovXx:     cov_q.xx     <= cfg_data_i;
        mhd_pkg::RegCovXy:     cov_q.xy     <= cfg_data_i;
        mhd_pkg::RegCovXa:     cov_q.xa     <= cfg_data_i;
        mhd_pkg::RegCovYy:     cov_q.yy     <= cfg_data_i;
        mhd_pkg::RegCovYa:     cov_q.ya     <= cfg_data_i;
        mhd_pkg::RegCovAa:     cov_q.aa     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= mhd_pkg::SettleCycles;
    end else if (cfg_valid_i) begin
      settle_q <= mhd_pkg::SettleCycles;
    end else if (!settled) begin
      settle_q <= settle_q - 3'd1;
    end
  end

  assign in_ready_o = quad_ready && settled;

  mhd_cov_calc u_cov (
    .clk_i (clk_i),
    .cov_i (cov_q),
    .cof_o (cof),
    .det_o (det)
  );

  mhd_quad u_quad (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i && settled),
    .ready_o      (quad_ready),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_angle_i  (pos_angle_i),
    .mean_xy_i    (mean_xy_q),
    .mean_angle_i (mean_angle_q),
    .cof_i        (cof),
    .valid_o      (quad_valid),
    .ready_i      (div_ready),
    .qf_o         (qf)
  );

  mhd_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (quad_valid),
    .ready_o       (div_ready),
    .qf_i          (qf),
    .det_i         (det),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .distance_sq_o (distance_sq_o),
    .is_infinite_o (is_infinite_o),
    .saturated_o   (saturated_o)
  );

endmodule

/* dv/mhd_checker.sv */
// checker: predicts the squared distance of every accepted point and compares results
`timescale 1ns / 1ps

module mhd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] pos_angle_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] distance_sq_i,
  input  logic        is_infinite_i,
  input  logic        saturated_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct {
    logic [31:0] dsq;
    logic        inf;
    logic        sat;
  } dist_res_t;

  logic [31:0] mean_xy, mean_ang;
  logic [31:0] c_xx, c_xy, c_xa, c_yy, c_ya, c_aa;
  dist_res_t   dist_q[$];

  function automatic dist_res_t predict_dist(input logic [15:0] px, input logic [15:0] py,
                                             input logic [15:0] pa);
    logic signed [127:0] a, b, c, d, e, f;
    logic signed [127:0] k00, k01, k02, k11, k12, k22, det;
    logic signed [127:0] dx, dy, da, p1, p2, qf, quo;
    dist_res_t r;
    a = $signed(c_xx); b = $signed(c_xy); c = $signed(c_xa);
    d = $signed(c_yy); e = $signed(c_ya); f = $signed(c_aa);
    k00 = d * f - e * e;
    k01 = c * e - b * f;
    k02 = b * e - c * d;
    k11 = a * f - c * c;
    k12 = b * c - a * e;
    k22 = a * d - b * b;
    det = k00 * a + k01 * b + k02 * c;
    r.dsq = 32'hffffffff;
    r.inf = 1'b1;
    r.sat = 1'b0;
    if (det <= 0) return r;
    r.inf = 1'b0;
    dx = $signed(px) - $signed(mean_xy[15:0]);
    dy = $signed(py) - $signed(mean_xy[31:16]);
    dx = dx * 32;
    dy = dy * 32;
    p1 = {112'b0, pa};
    p2 = {112'b0, mean_ang[15:0]};
    da = p1 - p2;
    if (p1 <= mhd_pkg::TwoPiQ13 && p2 <= mhd_pkg::TwoPiQ13 &&
        (da > $signed({112'b0, mhd_pkg::PiQ13}) || da < -$signed({112'b0, mhd_pkg::PiQ13})))
      da = (da < 0) ? da + mhd_pkg::TwoPiQ13 : da - mhd_pkg::TwoPiQ13;
    qf = k00 * dx * dx + k11 * dy * dy + k22 * da * da
       + k01 * 2 * dx * dy + k02 * 2 * dx * da + k12 * 2 * dy * da;
    if (qf < 0) begin
      r.dsq = 32'd0;
      r.sat = 1'b1;
      return r;
    end
    quo = (qf <<< 6) / det;
    if (quo > 128'sh0ffffffff) begin
      r.sat = 1'b1;
    end else begin
      r.dsq = quo[31:0];
    end
    return r;
  endfunction

  assign pending_o = dist_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_xy <= '0;
      mean_ang <= '0;
      c_xx <= 32'd65536; c_xy <= '0; c_xa <= '0;
      c_yy <= 32'd65536; c_ya <= '0; c_aa <= 32'd65536;
      errors_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          mhd_pkg::RegMeanXy:    mean_xy <= cfg_data_i;
          mhd_pkg::RegMeanAngle: mean_ang <= {16'b0, cfg_data_i[15:0]};
          mhd_pkg::RegCovXx:     c_xx <= cfg_data_i;
          mhd_pkg::RegCovXy:     c_xy <= cfg_data_i;
          mhd_pkg::RegCovXa:     c_xa <= cfg_data_i;
          mhd_pkg::RegCovYy:     c_yy <= cfg_data_i;
          mhd_pkg::RegCovYa:     c_ya <= cfg_data_i;
          mhd_pkg::RegCovAa:     c_aa <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        dist_q.push_back(predict_dist(pos_x_i, pos_y_i, pos_angle_i));
      if (out_valid_i && out_ready_i) begin
        if (dist_q.size() == 0) begin
          $error("result beat with no expectation");
          errors_o <= errors_o + 1;
        end else begin
          dist_res_t x;
          x = dist_q.pop_front();
          if (distance_sq_i !== x.dsq || is_infinite_i !== x.inf || saturated_i !== x.sat)
            errors_o <= errors_o + 1;
          if (distance_sq_i !== x.dsq)
            $error("distance_sq expected %h actual %h", x.dsq, distance_sq_i);
          if (is_infinite_i !== x.inf)
            $error("is_infinite expected %b actual %b", x.inf, is_infinite_i);
          if (saturated_i !== x.sat)
            $error("saturated expected %b actual %b", x.sat, saturated_i);
        end
      end
    end
  end

endmodule

/* dv/tb.sv */
// testbench top: clock, reset, point and register stimulus, verdict
`timescale 1ns / 1ps

module tb;

  localparam logic [3:0] RegUnused = 4'd15;

  logic               clk_i, rst_ni;
  logic               in_valid, in_ready, out_valid, out_ready;
  logic signed [15:0] pos_x, pos_y;
  logic [15:0]        pos_angle;
  logic [31:0]        distance_sq;
  logic               is_infinite, saturated;
  logic               cfg_valid, cfg_ready;
  logic [3:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 errors, pending;
  int                 tx_idle, rx_idle;

  mahalanobis_dist_x_y_angle uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_angle_i(pos_angle),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .distance_sq_o(distance_sq), .is_infinite_o(is_infinite), .saturated_o(saturated),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  mhd_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_angle_i(pos_angle),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .distance_sq_i(distance_sq), .is_infinite_i(is_infinite), .saturated_i(saturated),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) out_ready <= ($urandom_range(99) >= rx_idle);

  task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic [15:0] a);
    in_valid <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    pos_angle <= a;
    do @(posedge clk_i); while (!in_ready);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  task automatic set_cov(input logic [31:0] mxy, input logic [31:0] ma,
                         input logic [31:0] xx, input logic [31:0] xy,
                         input logic [31:0] xa, input logic [31:0] yy,
                         input logic [31:0] ya, input logic [31:0] aa);
    write_reg(mhd_pkg::RegMeanXy, mxy);
    write_reg(mhd_pkg::RegMeanAngle, ma);
    write_reg(mhd_pkg::RegCovXx, xx);
    write_reg(mhd_pkg::RegCovXy, xy);
    write_reg(mhd_pkg::RegCovXa, xa);
    write_reg(mhd_pkg::RegCovYy, yy);
    write_reg(mhd_pkg::RegCovYa, ya);
    write_reg(mhd_pkg::RegCovAa, aa);
  endtask

  task automatic pick_config(input int kind);
    case (kind)
      0: set_cov($urandom, $urandom_range(0, 51472), 32'h00010000, 0, 0,
                 32'h00010000, 0, 32'h00010000);
      1: set_cov($urandom, $urandom, $urandom_range(1 << 12, 1 << 24), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(1 << 12, 1 << 24),
                 $urandom_range(0, 255), $urandom_range(1 << 12, 1 << 24));
      2: set_cov($urandom, $urandom, 0, 0, 0, 0, 0, 0);
      3: set_cov($urandom, $urandom_range(0, 51472), 32'h00010000, 0, 0,
                 32'hffff0000, 0, 32'hffff0000);
      4: set_cov(32'hffffffff, 32'h0000ffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      5: set_cov($urandom, $urandom, 1, 0, 0, 1, 0, 1);
      6: set_cov(32'h80008000, 32'd51472, 32'h7fffffff, 0, 0, 32'h7fffffff, 0, 32'h7fffffff);
      default: set_cov($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
    endcase
    if ($urandom_range(1)) write_reg(RegUnused, $urandom);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    in_valid <= 1'b0;
    pos_x <= '0;
    pos_y <= '0;
    pos_angle <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    out_ready <= 1'b0;
    tx_idle = 34;
    rx_idle = 69;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset covariance, angle wrap edges
    send_point(16'h0000, 16'h0000, 16'd0);
    send_point(16'h8000, 16'h8000, 16'hffff);
    send_point(16'h7fff, 16'h7fff, 16'd25736);
    send_point(16'h8000, 16'h7fff, 16'd25737);
    send_point(16'h7fff, 16'h8000, 16'd51472);
    send_point(16'hffff, 16'h0001, 16'd51473);
    send_point(16'h0100, 16'hff00, 16'd12868);
    send_point(16'h5555, 16'haaaa, 16'haaaa);
    send_point(16'haaaa, 16'h5555, 16'h5555);
    drain();
    // mean at 2*pi, wrap toward zero
    set_cov(32'h7fff8000, 32'd51472, 32'h00010000, 0, 0, 32'h00010000, 0, 32'h00010000);
    send_point(16'h7fff, 16'h8000, 16'd0);
    send_point(16'h8000, 16'h7fff, 16'd25735);
    send_point(16'h0000, 16'h0000, 16'd51472);
    send_point(16'h0000, 16'h0000, 16'hffff);
    drain();
    // singular, indefinite and tiny covariance
    pick_config(2);
    send_point(16'h1234, 16'h4321, 16'd100);
    send_point(16'h8000, 16'h7fff, 16'hffff);
    drain();
    pick_config(3);
    send_point(16'h0000, 16'h7fff, 16'd0);
    send_point(16'h7fff, 16'h0000, 16'd0);
    send_point(16'h0000, 16'h0000, 16'd30000);
    drain();
    pick_config(5);
    send_point(16'h7fff, 16'h8000, 16'hffff);
    send_point(16'h0000, 16'h0000, 16'd0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4) begin
        tx_idle = 69;
        rx_idle = 34;
      end else if (ph == 7) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      pick_config((ph < 7) ? ph : $urandom_range(0, 7));
      for (int n = 0; n < 93; n++) begin
        send_point(rand_coord(), rand_coord(),
                   16'($urandom_range(1) ? $urandom_range(0, 51472) : $urandom_range(0, 65535)));
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/mhd_pkg.sv
hw/rtl/mhd_cov_calc.sv
hw/rtl/mhd_quad.sv
hw/rtl/mhd_div.sv
hw/rtl/mahalanobis_dist_x_y_angle.sv
dv/mhd_checker.sv
dv/tb.sv
